FILE: rtl/r2k_pkg.sv
`default_nettype none
package r2k_pkg;

   localparam logic [15:0] KANA_N         = 16'h3093;
   localparam logic [15:0] KANA_SMALL_TSU = 16'h3063;

   localparam logic REQ_FEED = 1'b0;
   localparam logic REQ_BKSP = 1'b1;

   localparam int NUM_RULES = 181;

   // one table entry: key bytes (zero padded), length, one or two kana
   typedef struct packed {
      logic [31:0] rom;
      logic [2:0]  len;
      logic [15:0] k0;
      logic [15:0] k1;
   } rule_type;

   // request passed from front to back
   typedef struct packed {
      logic       bksp;
      logic [7:0] key;
   } cmd_type;

   // result item
   typedef struct packed {
      logic        is_kana;
      logic [15:0] code;
      logic        last;
   } res_type;

   function automatic rule_type mk(input string s, input logic [15:0] a,
                                   input logic [15:0] b);
      rule_type r;
      int       i;
      r.rom = '0;
      r.len = 3'(s.len());
      for (i = 0; i < 4; i++) begin
         if (i < s.len()) r.rom[i*8 +: 8] = s[i];
      end
      r.k0 = a;
      r.k1 = b;
      return r;
   endfunction

   function automatic rule_type rule_at(input logic [7:0] idx);
      rule_type r;
      r = mk("", 16'h0, 16'h0);
      case (idx)
         8'd0: r = mk("a", 16'h3042, 0);     8'd1: r = mk("i", 16'h3044, 0);
         8'd2: r = mk("u", 16'h3046, 0);     8'd3: r = mk("e", 16'h3048, 0);
         8'd4: r = mk("o", 16'h304A, 0);
         8'd5: r = mk("ka", 16'h304B, 0);    8'd6: r = mk("ki", 16'h304D, 0);
         8'd7: r = mk("ku", 16'h304F, 0);    8'd8: r = mk("ke", 16'h3051, 0);
         8'd9: r = mk("ko", 16'h3053, 0);
         8'd10: r = mk("kya", 16'h304D, 16'h3083); 8'd11: r = mk("kyi", 16'h304D, 16'h3043);
         8'd12: r = mk("kyu", 16'h304D, 16'h3085); 8'd13: r = mk("kye", 16'h304D, 16'h3047);
         8'd14: r = mk("kyo", 16'h304D, 16'h3087);
         8'd15: r = mk("sa", 16'h3055, 0);   8'd16: r = mk("si", 16'h3057, 0);
         8'd17: r = mk("su", 16'h3059, 0);   8'd18: r = mk("se", 16'h305B, 0);
         8'd19: r = mk("so", 16'h305D, 0);
         8'd20: r = mk("shi", 16'h3057, 0);
         8'd21: r = mk("sha", 16'h3057, 16'h3083); 8'd22: r = mk("shu", 16'h3057, 16'h3085);
         8'd23: r = mk("she", 16'h3057, 16'h3047); 8'd24: r = mk("sho", 16'h3057, 16'h3087);
         8'd25: r = mk("sya", 16'h3057, 16'h3083); 8'd26: r = mk("syi", 16'h3057, 16'h3043);
         8'd27: r = mk("syu", 16'h3057, 16'h3085); 8'd28: r = mk("sye", 16'h3057, 16'h3047);
         8'd29: r = mk("syo", 16'h3057, 16'h3087);
         8'd30: r = mk("ta", 16'h305F, 0);   8'd31: r = mk("ti", 16'h3061, 0);
         8'd32: r = mk("tu", 16'h3064, 0);   8'd33: r = mk("te", 16'h3066, 0);
         8'd34: r = mk("to", 16'h3068, 0);
         8'd35: r = mk("chi", 16'h3061, 0);  8'd36: r = mk("tsu", 16'h3064, 0);
         8'd37: r = mk("cha", 16'h3061, 16'h3083); 8'd38: r = mk("chu", 16'h3061, 16'h3085);
         8'd39: r = mk("che", 16'h3061, 16'h3047); 8'd40: r = mk("cho", 16'h3061, 16'h3087);
         8'd41: r = mk("tya", 16'h3061, 16'h3083); 8'd42: r = mk("tyi", 16'h3061, 16'h3043);
         8'd43: r = mk("tyu", 16'h3061, 16'h3085); 8'd44: r = mk("tye", 16'h3061, 16'h3047);
         8'd45: r = mk("tyo", 16'h3061, 16'h3087);
         8'd46: r = mk("thi", 16'h3066, 16'h3043);
         8'd47: r = mk("na", 16'h306A, 0);   8'd48: r = mk("ni", 16'h306B, 0);
         8'd49: r = mk("nu", 16'h306C, 0);   8'd50: r = mk("ne", 16'h306D, 0);
         8'd51: r = mk("no", 16'h306E, 0);   8'd52: r = mk("nn", 16'h3093, 0);
         8'd53: r = mk("nya", 16'h306B, 16'h3083); 8'd54: r = mk("nyi", 16'h306B, 16'h3043);
         8'd55: r = mk("nyu", 16'h306B, 16'h3085); 8'd56: r = mk("nye", 16'h306B, 16'h3047);
         8'd57: r = mk("nyo", 16'h306B, 16'h3087);
         8'd58: r = mk("ha", 16'h306F, 0);   8'd59: r = mk("hi", 16'h3072, 0);
         8'd60: r = mk("fu", 16'h3075, 0);   8'd61: r = mk("hu", 16'h3075, 0);
         8'd62: r = mk("he", 16'h3078, 0);   8'd63: r = mk("ho", 16'h307B, 0);
         8'd64: r = mk("hya", 16'h3072, 16'h3083); 8'd65: r = mk("hyi", 16'h3072, 16'h3043);
         8'd66: r = mk("hyu", 16'h3072, 16'h3085); 8'd67: r = mk("hye", 16'h3072, 16'h3047);
         8'd68: r = mk("hyo", 16'h3072, 16'h3087);
         8'd69: r = mk("fa", 16'h3075, 16'h3041); 8'd70: r = mk("fi", 16'h3075, 16'h3043);
         8'd71: r = mk("fe", 16'h3075, 16'h3047); 8'd72: r = mk("fo", 16'h3075, 16'h3049);
         8'd73: r = mk("ma", 16'h307E, 0);   8'd74: r = mk("mi", 16'h307F, 0);
         8'd75: r = mk("mu", 16'h3080, 0);   8'd76: r = mk("me", 16'h3081, 0);
         8'd77: r = mk("mo", 16'h3082, 0);
         8'd78: r = mk("mya", 16'h307F, 16'h3083); 8'd79: r = mk("myi", 16'h307F, 16'h3043);
         8'd80: r = mk("myu", 16'h307F, 16'h3085); 8'd81: r = mk("mye", 16'h307F, 16'h3047);
         8'd82: r = mk("myo", 16'h307F, 16'h3087);
         8'd83: r = mk("ya", 16'h3084, 0);   8'd84: r = mk("yi", 16'h3044, 0);
         8'd85: r = mk("yu", 16'h3086, 0);   8'd86: r = mk("ye", 16'h3044, 16'h3047);
         8'd87: r = mk("yo", 16'h3088, 0);
         8'd88: r = mk("ra", 16'h3089, 0);   8'd89: r = mk("ri", 16'h308A, 0);
         8'd90: r = mk("ru", 16'h308B, 0);   8'd91: r = mk("re", 16'h308C, 0);
         8'd92: r = mk("ro", 16'h308D, 0);
         8'd93: r = mk("rya", 16'h308A, 16'h3083); 8'd94: r = mk("ryi", 16'h308A, 16'h3043);
         8'd95: r = mk("ryu", 16'h308A, 16'h3085); 8'd96: r = mk("rye", 16'h308A, 16'h3047);
         8'd97: r = mk("ryo", 16'h308A, 16'h3087);
         8'd98: r = mk("wa", 16'h308F, 0);   8'd99: r = mk("wi", 16'h3046, 16'h3043);
         8'd100: r = mk("wu", 16'h3046, 0);  8'd101: r = mk("we", 16'h3046, 16'h3047);
         8'd102: r = mk("wo", 16'h3092, 0);
         8'd103: r = mk("ga", 16'h304C, 0);  8'd104: r = mk("gi", 16'h304E, 0);
         8'd105: r = mk("gu", 16'h3050, 0);  8'd106: r = mk("ge", 16'h3052, 0);
         8'd107: r = mk("go", 16'h3054, 0);
         8'd108: r = mk("gya", 16'h304E, 16'h3083); 8'd109: r = mk("gyi", 16'h304E, 16'h3043);
         8'd110: r = mk("gyu", 16'h304E, 16'h3085); 8'd111: r = mk("gye", 16'h304E, 16'h3047);
         8'd112: r = mk("gyo", 16'h304E, 16'h3087);
         8'd113: r = mk("za", 16'h3056, 0);  8'd114: r = mk("zi", 16'h3058, 0);
         8'd115: r = mk("zu", 16'h305A, 0);  8'd116: r = mk("ze", 16'h305C, 0);
         8'd117: r = mk("zo", 16'h305E, 0);  8'd118: r = mk("ji", 16'h3058, 0);
         8'd119: r = mk("ja", 16'h3058, 16'h3083); 8'd120: r = mk("ju", 16'h3058, 16'h3085);
         8'd121: r = mk("je", 16'h3058, 16'h3047); 8'd122: r = mk("jo", 16'h3058, 16'h3087);
         8'd123: r = mk("zya", 16'h3058, 16'h3083); 8'd124: r = mk("zyi", 16'h3058, 16'h3043);
         8'd125: r = mk("zyu", 16'h3058, 16'h3085); 8'd126: r = mk("zye", 16'h3058, 16'h3047);
         8'd127: r = mk("zyo", 16'h3058, 16'h3087);
         8'd128: r = mk("da", 16'h3060, 0);  8'd129: r = mk("di", 16'h3062, 0);
         8'd130: r = mk("du", 16'h3065, 0);  8'd131: r = mk("de", 16'h3067, 0);
         8'd132: r = mk("do", 16'h3069, 0);
         8'd133: r = mk("dya", 16'h3062, 16'h3083); 8'd134: r = mk("dyi", 16'h3062, 16'h3043);
         8'd135: r = mk("dyu", 16'h3062, 16'h3085); 8'd136: r = mk("dye", 16'h3062, 16'h3047);
         8'd137: r = mk("dyo", 16'h3062, 16'h3087);
         8'd138: r = mk("dhi", 16'h3067, 16'h3043);
         8'd139: r = mk("ba", 16'h3070, 0);  8'd140: r = mk("bi", 16'h3073, 0);
         8'd141: r = mk("bu", 16'h3076, 0);  8'd142: r = mk("be", 16'h3079, 0);
         8'd143: r = mk("bo", 16'h307C, 0);
         8'd144: r = mk("bya", 16'h3073, 16'h3083); 8'd145: r = mk("byi", 16'h3073, 16'h3043);
         8'd146: r = mk("byu", 16'h3073, 16'h3085); 8'd147: r = mk("bye", 16'h3073, 16'h3047);
         8'd148: r = mk("byo", 16'h3073, 16'h3087);
         8'd149: r = mk("pa", 16'h3071, 0);  8'd150: r = mk("pi", 16'h3074, 0);
         8'd151: r = mk("pu", 16'h3077, 0);  8'd152: r = mk("pe", 16'h307A, 0);
         8'd153: r = mk("po", 16'h307D, 0);
         8'd154: r = mk("pya", 16'h3074, 16'h3083); 8'd155: r = mk("pyi", 16'h3074, 16'h3043);
         8'd156: r = mk("pyu", 16'h3074, 16'h3085); 8'd157: r = mk("pye", 16'h3074, 16'h3047);
         8'd158: r = mk("pyo", 16'h3074, 16'h3087);
         8'd159: r = mk("xa", 16'h3041, 0);  8'd160: r = mk("xi", 16'h3043, 0);
         8'd161: r = mk("xu", 16'h3045, 0);  8'd162: r = mk("xe", 16'h3047, 0);
         8'd163: r = mk("xo", 16'h3049, 0);
         8'd164: r = mk("xya", 16'h3083, 0); 8'd165: r = mk("xyu", 16'h3085, 0);
         8'd166: r = mk("xyo", 16'h3087, 0);
         8'd167: r = mk("xtu", 16'h3063, 0); 8'd168: r = mk("xtsu", 16'h3063, 0);
         8'd169: r = mk("xwa", 16'h308E, 0);
         8'd170: r = mk("la", 16'h3041, 0);  8'd171: r = mk("li", 16'h3043, 0);
         8'd172: r = mk("lu", 16'h3045, 0);  8'd173: r = mk("le", 16'h3047, 0);
         8'd174: r = mk("lo", 16'h3049, 0);
         8'd175: r = mk("lya", 16'h3083, 0); 8'd176: r = mk("lyu", 16'h3085, 0);
         8'd177: r = mk("lyo", 16'h3087, 0);
         8'd178: r = mk("ltu", 16'h3063, 0); 8'd179: r = mk("ltsu", 16'h3063, 0);
         8'd180: r = mk("n'", 16'h3093, 0);
         default: r = mk("", 16'h0, 16'h0);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/r2k_front.sv
`default_nettype none
module r2k_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire r2k_pkg::cmd_type in_cmd,
   output logic                 q_valid,
   input  wire                  q_ready,
   output r2k_pkg::cmd_type     q_cmd
);
   import r2k_pkg::*;

   // two-entry queue between front and back
   cmd_type    mem_ff [2];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_cmd;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

FILE: rtl/r2k_back.sv
`default_nettype none
module r2k_back #(
   parameter int MAX_PENDING = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   output logic                 q_ready,
   input  wire r2k_pkg::cmd_type q_cmd,
   output logic                 out_valid,
   input  wire                  out_ready,
   output r2k_pkg::res_type     out_res
);
   import r2k_pkg::*;

   localparam int CW = $clog2(MAX_PENDING + 1);
   localparam int IW = $clog2(MAX_PENDING);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_K1   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]    st_ff, st_in;
   logic [7:0]    buf_ff [MAX_PENDING];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    ridx_ff, ridx_in;
   logic          pfx_ff, pfx_in;
   logic [15:0]   k1_ff, k1_in;
   res_type       hold_ff, hold_in;
   logic          hold_v_ff, hold_v_in;
   res_type       obuf_ff;
   logic          ov_ff;
   logic          drop, shift_in;
   logic [7:0]    key_in;
   logic          wr_key;
   rule_type      rl;
   logic          heq;
   logic [7:0]    c0, c1;
   logic          emit_v;
   res_type       emit_r;
   logic          flush;
   logic          can_emit;

   assign rl = rule_at(ridx_ff);
   assign c0 = buf_ff[0];
   assign c1 = buf_ff[1];

   always_comb begin
      heq = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (i < int'(cnt_ff) && rl.rom[i*8 +: 8] != buf_ff[i]) heq = 1'b0;
      end
   end

   // one-entry holding stage: a result waits here for the following one
   // so that last can be set on the final result
   assign can_emit = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_res   = obuf_ff;

   always_comb begin
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      ridx_in    = ridx_ff;
      pfx_in     = pfx_ff;
      k1_in      = k1_ff;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      q_ready    = 1'b0;
      drop       = 1'b0;
      wr_key     = 1'b0;
      key_in     = q_cmd.key;
      emit_v     = 1'b0;
      emit_r     = '0;
      flush      = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               if (q_cmd.bksp == REQ_BKSP) begin
                  if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
               end else begin
                  if (int'(cnt_ff) < MAX_PENDING) begin
                     wr_key = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
                  st_in   = S_SCAN;
                  ridx_in = '0;
                  pfx_in  = 1'b0;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff == '0) begin
               st_in = S_FIN;
            end else if (heq && CW'(rl.len) == cnt_ff) begin
               k1_in  = rl.k1;
               emit_v = 1'b1;
               emit_r = '{is_kana: 1'b1, code: rl.k0, last: 1'b0};
               st_in  = S_K1;
            end else begin
               if (heq && CW'(rl.len) > cnt_ff) pfx_in = 1'b1;
               if (ridx_ff == 8'(NUM_RULES - 1)) st_in = S_DEC;
               else ridx_in = ridx_ff + 1'b1;
            end
         end
         S_K1: begin
            cnt_in = '0;
            if (k1_ff != '0) begin
               emit_v = 1'b1;
               emit_r = '{is_kana: 1'b1, code: k1_ff, last: 1'b0};
            end
            st_in = S_FIN;
         end
         S_DEC: begin
            if (pfx_ff) begin
               st_in = S_FIN;
            end else begin
               emit_v = 1'b1;
               drop   = 1'b1;
               if (cnt_ff >= CW'(2) && c0 == "n" && c1 != "a" && c1 != "i" &&
                   c1 != "u" && c1 != "e" && c1 != "o" && c1 != "n" &&
                   c1 != "y" && c1 != "'")
                  emit_r = '{is_kana: 1'b1, code: KANA_N, last: 1'b0};
               else if (cnt_ff >= CW'(2) && c0 == c1 && c0 != "n")
                  emit_r = '{is_kana: 1'b1, code: KANA_SMALL_TSU, last: 1'b0};
               else
                  emit_r = '{is_kana: 1'b0, code: {8'h00, c0}, last: 1'b0};
               cnt_in  = cnt_ff - 1'b1;
               st_in   = S_SCAN;
               ridx_in = '0;
               pfx_in  = 1'b0;
            end
         end
         S_FIN: begin
            flush = 1'b1;
            if (!hold_v_ff || can_emit) begin
               hold_v_in = 1'b0;
               st_in     = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      // stall emits until the output can take the held result
      if (emit_v && hold_v_ff && !can_emit) begin
         st_in = st_ff; cnt_in = cnt_ff; ridx_in = ridx_ff; pfx_in = pfx_ff;
         k1_in = k1_ff; drop = 1'b0;
      end else if (emit_v) begin
         hold_in   = emit_r;
         hold_v_in = 1'b1;
      end
   end

   assign shift_in = drop && !(emit_v && hold_v_ff && !can_emit);

   always_ff @(posedge clock) begin
      if (wr_key) buf_ff[cnt_ff[IW-1:0]] <= key_in;
      if (shift_in) begin
         for (int i = 1; i < MAX_PENDING; i++) buf_ff[i-1] <= buf_ff[i];
      end
      hold_ff <= hold_in;
      k1_ff   <= k1_in;
      ridx_ff <= ridx_in;
      if (can_emit && hold_v_ff && ((emit_v) || (flush))) begin
         obuf_ff <= '{is_kana: hold_ff.is_kana, code: hold_ff.code, last: flush};
      end
      if (reset) begin
         st_ff      <= S_IDLE;
         cnt_ff     <= '0;
         pfx_ff     <= 1'b0;
         hold_v_ff  <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         pfx_ff     <= pfx_in;
         hold_v_ff  <= hold_v_in;
         if (can_emit && hold_v_ff && (emit_v || flush)) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/romaji_to_kana_transliterator.sv
// Romaji to hiragana transliterator. Each request carries either a key byte or a
// backspace. Key bytes collect in a pending buffer of up to MAX_PENDING bytes;
// after each key the buffer is matched against a 181-entry romaji rom, one
// entry per clock, and a match, a syllabic n, a doubled consonant or a raw
// byte is sent out per pass until the buffer is empty or a strict prefix.
// A key request therefore takes up to MAX_PENDING conversion passes, each a
// scan of the rom; a backspace gives no response. Requests enter a two-deep
// queue, so the sender is held only once two requests wait for the converter.
// Responses carry a code point (or the raw byte) and tlast on the final
// response of a request.
`default_nettype none
module romaji_to_kana_transliterator #(
   parameter int MAX_PENDING = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // key_byte
   input  wire         req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // code
   output logic        rsp_tuser,   // is_kana
   output logic        rsp_tlast    // last
);
   import r2k_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready;
   res_type res;

   assign in_cmd = '{bksp: req_tuser, key: req_tdata};

   // front: request queue
   r2k_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid, .q_ready, .q_cmd
   );

   // back: rom scan and emit rules
   r2k_back #(.MAX_PENDING(MAX_PENDING)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_cmd,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = res.code;
   assign rsp_tuser = res.is_kana;
   assign rsp_tlast = res.last;
endmodule
`default_nettype wire

FILE: rtl/r2k_checker.sv
`default_nettype none
module r2k_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response dropped while stalled");
   a_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:8] == 8'h00)
      else $error("raw byte wider than 8 bits");
   a_kana: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:8] == 8'h30)
      else $error("kana outside hiragana block");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response after reset");
   a_rdy: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request side not ready after reset");
endmodule

bind romaji_to_kana_transliterator r2k_checker u_chk (.*);
`default_nettype wire
